### hw/rtl/llhr_pkg.sv
// ----------------------------------------------------------------------------
// llhr_pkg
// shared types, codes and constants of the log-linear histogram recorder
// ----------------------------------------------------------------------------
package llhr_pkg;

    localparam int COUNTS_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(COUNTS_DEPTH);
    localparam int PTR_W        = ADDR_W + 1;
    localparam int LEN_W        = 24;
    localparam int NUM_W        = 78;
    localparam int DIV_DIGIT_W  = 6;
    localparam int DIV_T_W      = 14 + DIV_DIGIT_W;
    localparam int DIV_STEPS    = NUM_W / DIV_DIGIT_W;
    localparam int DCNT_W       = $clog2(DIV_STEPS);

    localparam logic [62:0] HIGH_RESET   = 63'd4294967295;
    localparam logic [2:0]  DIGITS_RESET = 3'd2;
    localparam logic [13:0] PCT_MAX      = 14'd10000;
    localparam logic [13:0] PCT_DIV      = 14'd10000;
    localparam logic [12:0] PCT_ROUND    = 13'd5000;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_COUNT  = 2'd1,
        OP_PCTL   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_FALL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_HIGHEST = 2'd0,
        CFG_DIGITS  = 2'd1,
        CFG_SPARE2  = 2'd2,
        CFG_SPARE3  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_op         op;
        logic [62:0] sample_value;
        logic [31:0] increment;
        logic [15:0] percentile;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [63:0] bucket_count_out;
        logic [62:0] percentile_value;
        logic [63:0] total_out;
        logic [62:0] minimum_out;
        logic [62:0] maximum_out;
    } t_out_word;

    typedef struct packed {
        logic clr_step;
        logic cap_in;
        logic clamp;
        logic lzc;
        logic index;
        logic rd_idx;
        logic rmw;
        logic mul_lo;
        logic mul_hi;
        logic div_step;
        logic walk_start;
        logic walk_step;
        logic pval;
        logic walk_fail;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic short_cfg;
        logic div_last;
        logic walk_hit;
        logic walk_end;
        logic out_free;
    } t_dp_sts;

    // sub-bucket half magnitude by digit count, out-of-range digits saturate
    function automatic logic [4:0] half_mag(input logic [2:0] digits);
        logic [4:0] hm;
        unique case (digits)
            3'd0, 3'd1: hm = 5'd4;
            3'd2:       hm = 5'd7;
            3'd3:       hm = 5'd10;
            3'd4:       hm = 5'd14;
            default:    hm = 5'd17;
        endcase
        return hm;
    endfunction

endpackage

### hw/rtl/llhr_ram.sv
// ----------------------------------------------------------------------------
// llhr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module llhr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/llhr_dp.sv
// ----------------------------------------------------------------------------
// llhr_dp
// datapath: layout derivation, indexing, counter store, divider, walk, output
// ----------------------------------------------------------------------------
module llhr_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_hit,
    input  llhr_pkg::t_cfg_idx   i_cfg_index,
    input  logic [62:0]          i_cfg_data,
    input  llhr_pkg::t_in_word   i_in_word,
    input  llhr_pkg::t_dp_cmd    i_cmd,
    output llhr_pkg::t_dp_sts    o_sts,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output llhr_pkg::t_out_word  o_out_word
);

    // configuration and layout
    logic [62:0]                r_high;
    logic [2:0]                 r_digits;
    logic                       r_der_init;
    logic                       r_der_busy;
    logic [4:0]                 r_hm;
    logic [62:0]                r_eff;
    logic [63:0]                r_track;
    logic [5:0]                 r_bkt;
    logic [llhr_pkg::LEN_W-1:0] r_len;
    logic                       r_short;

    // item
    llhr_pkg::t_op              r_op;
    logic [62:0]                r_v;
    logic [31:0]                r_inc;
    logic [13:0]                r_p;
    logic [62:0]                r_vc;
    logic [5:0]                 r_bucket;
    logic [llhr_pkg::LEN_W-1:0] r_idx;
    logic                       r_idx_ok;
    llhr_pkg::t_status          r_status;
    logic [63:0]                r_cnt;
    logic [62:0]                r_pval;

    // statistics
    logic [63:0] r_total;
    logic [62:0] r_min;
    logic [62:0] r_max;

    // clear sweep
    logic [llhr_pkg::ADDR_W-1:0] r_clr;

    // percentile target
    logic [45:0]                  r_prod;
    logic [llhr_pkg::NUM_W-1:0]   r_num;
    logic [13:0]                  r_rem;
    logic [llhr_pkg::DCNT_W-1:0]  r_dcnt;

    // walk
    logic [llhr_pkg::PTR_W-1:0]  r_wp;
    logic                        r_pend;
    logic [llhr_pkg::ADDR_W-1:0] r_pidx;
    logic [llhr_pkg::ADDR_W-1:0] r_fidx;
    logic [63:0]                 r_run;

    // output register
    logic                 r_ovld;
    llhr_pkg::t_out_word  r_out;

    // ram
    logic                        ram_we;
    logic [llhr_pkg::ADDR_W-1:0] ram_waddr;
    logic [63:0]                 ram_wdata;
    logic [llhr_pkg::ADDR_W-1:0] ram_raddr;
    logic [63:0]                 ram_rdata;

    logic [62:0]                     sub_mask;
    logic [62:0]                     lz_word;
    logic [5:0]                      lz_len;
    logic [llhr_pkg::LEN_W-1:0]      idx_n;
    logic [63:0]                     rmw_sum;
    logic [llhr_pkg::DIV_T_W-1:0]    div_t;
    logic [llhr_pkg::DIV_DIGIT_W-1:0] div_q;
    logic [llhr_pkg::DIV_T_W-1:0]    div_sub;
    logic [63:0]                     target;
    logic [64:0]                     run_sum;
    logic [63:0]                     run_n;
    logic                            walk_more;
    logic [6:0]                      bkt_p1;

    function automatic logic [62:0] entry_value(input logic [llhr_pkg::ADDR_W-1:0] idx,
                                                input logic [4:0] hm);
        logic [llhr_pkg::LEN_W-1:0] ix;
        logic [llhr_pkg::LEN_W-1:0] half;
        logic [llhr_pkg::LEN_W-1:0] ii;
        logic [llhr_pkg::LEN_W-1:0] jj;
        logic [63:0]                sh;
        logic [62:0]                res;
        ix   = llhr_pkg::LEN_W'(idx);
        half = llhr_pkg::LEN_W'(1) << hm;
        ii   = (ix >> hm) - llhr_pkg::LEN_W'(1);
        jj   = (ix & (half - llhr_pkg::LEN_W'(1))) + half;
        sh   = 64'(jj) << ii[5:0];
        if (ix < (half << 1)) begin
            res = 63'(idx);
        end else if (ii > llhr_pkg::LEN_W'(63)) begin
            res = '0;
        end else begin
            res = sh[62:0];
        end
        return res;
    endfunction

    llhr_ram #(
        .WIDTH (64),
        .DEPTH (llhr_pkg::COUNTS_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        sub_mask = (63'd1 << (r_hm + 5'd1)) - 63'd1;
        lz_word  = r_vc | sub_mask;
        lz_len   = '0;
        for (int k = 0; k < 63; k++) begin
            if (lz_word[k]) begin
                lz_len = 6'(k + 1);
            end
        end
        idx_n   = (llhr_pkg::LEN_W'(r_bucket) << r_hm) + llhr_pkg::LEN_W'(r_vc >> r_bucket);
        rmw_sum = ram_rdata + 64'(r_inc);
        // one quotient digit: compare against every constant multiple of the divisor
        div_t   = {r_rem, r_num[llhr_pkg::NUM_W-1 -: llhr_pkg::DIV_DIGIT_W]};
        div_q   = '0;
        div_sub = '0;
        for (int c = 1; c < (1 << llhr_pkg::DIV_DIGIT_W); c++) begin
            if (div_t >= llhr_pkg::DIV_T_W'(c * int'(llhr_pkg::PCT_DIV))) begin
                div_q   = llhr_pkg::DIV_DIGIT_W'(c);
                div_sub = llhr_pkg::DIV_T_W'(c * int'(llhr_pkg::PCT_DIV));
            end
        end
        target  = (r_num[63:0] == 64'd0) ? 64'd1 : r_num[63:0];
        run_sum = 65'(r_run) + 65'(ram_rdata);
        run_n   = run_sum[64] ? '1 : run_sum[63:0];
        walk_more = (llhr_pkg::LEN_W'(r_wp) < r_len);
        bkt_p1  = 7'(r_bkt) + 7'd1;

        ram_we    = 1'b0;
        ram_waddr = r_idx[llhr_pkg::ADDR_W-1:0];
        ram_wdata = rmw_sum;
        if (i_cmd.clr_step) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else if (i_cmd.rmw && r_idx_ok && r_op == llhr_pkg::OP_RECORD) begin
            ram_we = 1'b1;
        end
        ram_raddr = i_cmd.walk_step ? r_wp[llhr_pkg::ADDR_W-1:0]
                                    : r_idx[llhr_pkg::ADDR_W-1:0];
    end

    // layout derivation, one shift a cycle, well inside the clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high     <= llhr_pkg::HIGH_RESET;
            r_digits   <= llhr_pkg::DIGITS_RESET;
            r_der_init <= 1'b1;
            r_der_busy <= 1'b0;
            r_short    <= 1'b0;
        end else if (i_cfg_hit) begin
            if (i_cfg_index == llhr_pkg::CFG_HIGHEST) begin
                r_high <= i_cfg_data;
            end else begin
                r_digits <= i_cfg_data[2:0];
            end
            r_der_init <= 1'b1;
            r_der_busy <= 1'b0;
        end else if (r_der_init) begin
            r_der_init <= 1'b0;
            r_der_busy <= 1'b1;
            r_hm       <= llhr_pkg::half_mag(r_digits);
            r_eff      <= (r_high < 63'd2) ? 63'd2 : r_high;
            r_track    <= (64'd1 << (llhr_pkg::half_mag(r_digits) + 5'd1)) - 64'd1;
            r_bkt      <= 6'd1;
        end else if (r_der_busy) begin
            if (r_track < 64'(r_eff)) begin
                r_track <= r_track << 1;
                r_bkt   <= r_bkt + 6'd1;
            end else begin
                r_der_busy <= 1'b0;
                r_len      <= llhr_pkg::LEN_W'(bkt_p1) << r_hm;
                r_short    <= (llhr_pkg::LEN_W'(bkt_p1) << r_hm)
                              > llhr_pkg::LEN_W'(llhr_pkg::COUNTS_DEPTH);
            end
        end
    end

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (i_cfg_hit) begin
                r_clr <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // item payload path
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_total <= '0;
            r_min   <= '1;
            r_max   <= '0;
        end
        if (i_cmd.cap_in) begin
            r_op     <= i_in_word.op;
            r_v      <= i_in_word.sample_value;
            r_inc    <= i_in_word.increment;
            r_p      <= (i_in_word.percentile > 16'(llhr_pkg::PCT_MAX))
                        ? llhr_pkg::PCT_MAX : i_in_word.percentile[13:0];
            r_status <= r_short ? llhr_pkg::ST_SHORT : llhr_pkg::ST_OK;
            r_cnt    <= '0;
            r_pval   <= '0;
        end
        if (i_cmd.clamp) begin
            r_vc <= (r_v > r_eff) ? r_eff : r_v;
        end
        if (i_cmd.lzc) begin
            r_bucket <= lz_len - 6'(r_hm + 5'd1);
        end
        if (i_cmd.index) begin
            r_idx    <= idx_n;
            r_idx_ok <= idx_n < r_len;
        end
        if (i_cmd.rmw) begin
            if (r_idx_ok) begin
                r_cnt <= (r_op == llhr_pkg::OP_RECORD) ? rmw_sum : ram_rdata;
            end
            if (r_op == llhr_pkg::OP_RECORD) begin
                r_total <= r_total + 64'(r_inc);
                if (r_v < r_min) begin
                    r_min <= r_v;
                end
                if (r_v > r_max) begin
                    r_max <= r_v;
                end
            end
        end
        // target = floor((p * total + 5000) / 10000), six quotient bits a cycle
        if (i_cmd.mul_lo) begin
            r_prod <= 46'(r_p) * 46'(r_total[31:0]);
        end
        if (i_cmd.mul_hi) begin
            r_num  <= (llhr_pkg::NUM_W'(46'(r_p) * 46'(r_total[63:32])) << 32)
                      + llhr_pkg::NUM_W'(r_prod) + llhr_pkg::NUM_W'(llhr_pkg::PCT_ROUND);
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= 14'(div_t - div_sub);
            r_num  <= {r_num[llhr_pkg::NUM_W-llhr_pkg::DIV_DIGIT_W-1:0], div_q};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.walk_start) begin
            r_wp   <= '0;
            r_pend <= 1'b0;
            r_run  <= '0;
        end
        if (i_cmd.walk_step) begin
            r_pend <= walk_more;
            r_pidx <= r_wp[llhr_pkg::ADDR_W-1:0];
            if (walk_more) begin
                r_wp <= r_wp + 1'b1;
            end
            if (r_pend) begin
                r_run  <= run_n;
                r_fidx <= r_pidx;
            end
        end
        if (i_cmd.pval) begin
            r_pval <= entry_value(r_fidx, r_hm);
        end
        if (i_cmd.walk_fail) begin
            r_status <= llhr_pkg::ST_FALL;
        end
        if (i_cmd.load_out) begin
            r_out.status           <= r_status;
            r_out.bucket_count_out <= r_cnt;
            r_out.percentile_value <= r_pval;
            r_out.total_out        <= r_total;
            r_out.minimum_out      <= r_min;
            r_out.maximum_out      <= r_max;
        end
    end

    always_comb begin
        o_sts.clr_last  = &r_clr;
        o_sts.short_cfg = r_short;
        o_sts.div_last  = (r_dcnt == llhr_pkg::DCNT_W'(llhr_pkg::DIV_STEPS - 1));
        o_sts.walk_hit  = r_pend && (run_n >= target);
        o_sts.walk_end  = !r_pend && !walk_more;
        o_sts.out_free  = !r_ovld || !i_out_stall;
    end

    assign o_out_valid = r_ovld;
    assign o_out_word  = r_out;

    a_clr_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_step |-> ram_we && ram_wdata == 64'd0)
        else $error("clear step without zero write");
    a_no_store_on_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rmw && r_short) |-> !ram_we)
        else $error("store written with oversized layout");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && i_out_stall) |=> r_ovld && $stable(r_out))
        else $error("stalled result changed");

endmodule

### hw/rtl/llhr_ctrl.sv
// ----------------------------------------------------------------------------
// llhr_ctrl
// sequencer of clear sweep, record, count and percentile operations
// ----------------------------------------------------------------------------
module llhr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_hit,
    input  logic               i_in_valid,
    input  llhr_pkg::t_op      i_in_op,
    output logic               o_in_stall,
    input  llhr_pkg::t_dp_sts  i_sts,
    output llhr_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CLAMP,
        S_LZC,
        S_INDEX,
        S_READ,
        S_RMW,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV,
        S_WALK,
        S_PVAL,
        S_DONE
    } t_state;

    t_state r_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd            = '0;
        o_cmd.clr_step   = (r_state == S_CLEAR);
        o_cmd.cap_in     = accept;
        o_cmd.clamp      = (r_state == S_CLAMP);
        o_cmd.lzc        = (r_state == S_LZC);
        o_cmd.index      = (r_state == S_INDEX);
        o_cmd.rd_idx     = (r_state == S_READ);
        o_cmd.rmw        = (r_state == S_RMW);
        o_cmd.mul_lo     = (r_state == S_MUL_LO);
        o_cmd.mul_hi     = (r_state == S_MUL_HI);
        o_cmd.div_step   = (r_state == S_DIV);
        o_cmd.walk_start = (r_state == S_DIV) && i_sts.div_last;
        o_cmd.walk_step  = (r_state == S_WALK);
        o_cmd.walk_fail  = (r_state == S_WALK) && !i_sts.walk_hit && i_sts.walk_end;
        o_cmd.pval       = (r_state == S_PVAL);
        o_cmd.load_out   = (r_state == S_DONE) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else if (i_cfg_hit) begin
            r_state <= S_CLEAR;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        priority if (i_sts.short_cfg) begin
                            r_state <= S_DONE;
                        end else if (i_in_op == llhr_pkg::OP_RECORD
                                     || i_in_op == llhr_pkg::OP_COUNT) begin
                            r_state <= S_CLAMP;
                        end else if (i_in_op == llhr_pkg::OP_PCTL) begin
                            r_state <= S_MUL_LO;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_CLAMP:  r_state <= S_LZC;
                S_LZC:    r_state <= S_INDEX;
                S_INDEX:  r_state <= S_READ;
                S_READ:   r_state <= S_RMW;
                S_RMW:    r_state <= S_DONE;
                S_MUL_LO: r_state <= S_MUL_HI;
                S_MUL_HI: r_state <= S_DIV;
                S_DIV: begin
                    if (i_sts.div_last) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    priority if (i_sts.walk_hit) begin
                        r_state <= S_PVAL;
                    end else if (i_sts.walk_end) begin
                        r_state <= S_DONE;
                    end
                end
                S_PVAL:   r_state <= S_DONE;
                S_DONE: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default:  r_state <= S_CLEAR;
            endcase
        end
    end

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_hit |=> r_state == S_CLEAR)
        else $error("config write did not start clear sweep");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_cfg_hit) |=> r_state != S_IDLE)
        else $error("accepted word left controller idle");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result loaded over waiting result");

endmodule

### hw/rtl/log_linear_histogram_recorder.sv
// ----------------------------------------------------------------------------
// log_linear_histogram_recorder
// record and count query: clamp, leading zeros, index, store read, update, result
// percentile query: product, digit-serial divider, store walk, entry value
// flow: one word at a time, next word taken the cycle after the result
// is registered, input stalled from acceptance until then
// reset: clear sweep over all 4096 entries of the counter store, input stalled;
// each write of the highest-value or digits register starts the same sweep again
// ----------------------------------------------------------------------------
module log_linear_histogram_recorder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  llhr_pkg::t_cfg_idx   i_cfg_index,
    input  logic [62:0]          i_cfg_data,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  llhr_pkg::t_in_word   i_in_word,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output llhr_pkg::t_out_word  o_out_word
);

    // only the two defined registers rederive the layout and clear the store
    logic               cfg_hit;
    llhr_pkg::t_dp_cmd  cmd;
    llhr_pkg::t_dp_sts  sts;

    assign cfg_hit = i_cfg_we && (i_cfg_index == llhr_pkg::CFG_HIGHEST
                                  || i_cfg_index == llhr_pkg::CFG_DIGITS);

    // sequencer: clear sweep, index pipeline, divider and walk control
    llhr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_hit  (cfg_hit),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_word.op),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: layout, counter store, target divider, walk and result register
    llhr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_hit   (cfg_hit),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the log-linear histogram recorder: a queue-fed
// driver and a monitor with random idling on both sides; a local model of
// the counter store predicts every result word, which is compared field by
// field; runs through several layouts, short-store ones among them
// ----------------------------------------------------------------------------
module tb;

    localparam int  LIMIT_CYCLES = 20000000;
    localparam logic [62:0] MAX63 = {63{1'b1}};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    llhr_pkg::t_cfg_idx   i_cfg_index = llhr_pkg::CFG_HIGHEST;
    logic [62:0]          i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    llhr_pkg::t_in_word   i_in_word = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    llhr_pkg::t_out_word  o_out_word;

    log_linear_histogram_recorder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #2 i_clk = ~i_clk;

    // model of the histogram: store, totals and derived layout
    logic [63:0] hist_counts [llhr_pkg::COUNTS_DEPTH];
    logic [63:0] hist_total;
    logic [62:0] hist_min;
    logic [62:0] hist_max;
    logic [62:0] cfg_highest;
    logic [2:0]  cfg_digits;
    int unsigned lay_hm;
    logic [63:0] lay_high;
    logic [63:0] lay_len;
    bit          lay_short;

    llhr_pkg::t_in_word  pending_words [$];
    llhr_pkg::t_out_word expected_words [$];
    int        mismatches = 0;
    int        cycle_count = 0;
    int        send_gap = 0;
    int        recv_wait = 0;
    bit        idle_on = 1'b1;

    // derive layout from the registers, then clear store and totals
    function void relayout();
        logic [2:0]  d;
        logic [63:0] track;
        int unsigned b;
        d = cfg_digits;
        if (d < 3'd1) d = 3'd1;
        if (d > 3'd5) d = 3'd5;
        case (d)
            3'd1: lay_hm = 4;
            3'd2: lay_hm = 7;
            3'd3: lay_hm = 10;
            3'd4: lay_hm = 14;
            default: lay_hm = 17;
        endcase
        lay_high = (cfg_highest < 63'd2) ? 64'd2 : {1'b0, cfg_highest};
        track = (64'd1 << (lay_hm + 1)) - 64'd1;
        b = 1;
        while (track < lay_high) begin
            track = track << 1;
            b++;
        end
        lay_len = (64'(b) + 64'd1) << lay_hm;
        lay_short = lay_len > 64'(llhr_pkg::COUNTS_DEPTH);
        foreach (hist_counts[k]) hist_counts[k] = '0;
        hist_total = '0;
        hist_min = MAX63;
        hist_max = '0;
    endfunction

    function logic [63:0] slot_of(logic [62:0] value);
        logic [63:0] v;
        logic [63:0] sub_mask;
        int unsigned nbits;
        int unsigned bkt;
        sub_mask = (64'd1 << (lay_hm + 1)) - 64'd1;
        v = {1'b0, value};
        if (v > lay_high) v = lay_high;
        nbits = 0;
        for (int k = 0; k < 64; k++) if ((v | sub_mask) >> k) nbits = k + 1;
        bkt = nbits - (lay_hm + 1);
        return ((64'(bkt) + 64'd1) << lay_hm) + (v >> bkt) - (64'd1 << lay_hm);
    endfunction

    function logic [62:0] slot_floor(logic [63:0] slot);
        logic [63:0] half;
        logic [63:0] i;
        logic [63:0] j;
        half = 64'd1 << lay_hm;
        if (slot < 2 * half) return slot[62:0];
        i = (slot >> lay_hm) - 64'd1;
        j = (slot & (half - 64'd1)) + half;
        if (i > 64'd63) return '0;
        return 63'(j << i);
    endfunction

    // expected result word for one accepted input word, updates the model
    function llhr_pkg::t_out_word histogram_result(llhr_pkg::t_in_word w);
        llhr_pkg::t_out_word r;
        logic [63:0] slot;
        logic [63:0] pct;
        logic [63:0] target;
        logic [63:0] running;
        bit          hit;
        r = '0;
        r.status = llhr_pkg::ST_OK;
        if (lay_short) begin
            r.status = llhr_pkg::ST_SHORT;
        end else if (w.op == llhr_pkg::OP_RECORD) begin
            slot = slot_of(w.sample_value);
            if (slot < lay_len && slot < llhr_pkg::COUNTS_DEPTH) begin
                hist_counts[slot] = hist_counts[slot] + 64'(w.increment);
                r.bucket_count_out = hist_counts[slot];
            end
            hist_total = hist_total + 64'(w.increment);
            if (w.sample_value < hist_min) hist_min = w.sample_value;
            if (w.sample_value > hist_max) hist_max = w.sample_value;
        end else if (w.op == llhr_pkg::OP_COUNT) begin
            slot = slot_of(w.sample_value);
            if (slot < lay_len && slot < llhr_pkg::COUNTS_DEPTH)
                r.bucket_count_out = hist_counts[slot];
        end else if (w.op == llhr_pkg::OP_PCTL) begin
            pct = (w.percentile > 16'd10000) ? 64'd10000 : 64'(w.percentile);
            target = pct * (hist_total / 64'd10000)
                   + (pct * (hist_total % 64'd10000) + 64'd5000) / 64'd10000;
            if (target < 64'd1) target = 64'd1;
            running = '0;
            hit = 1'b0;
            for (int k = 0; k < llhr_pkg::COUNTS_DEPTH && 64'(k) < lay_len; k++) begin
                running = (running > ~hist_counts[k]) ? '1 : running + hist_counts[k];
                if (running >= target) begin
                    r.percentile_value = slot_floor(64'(k));
                    hit = 1'b1;
                    break;
                end
            end
            if (!hit) r.status = llhr_pkg::ST_FALL;
        end
        r.total_out = hist_total;
        r.minimum_out = hist_min;
        r.maximum_out = hist_max;
        return r;
    endfunction

    function int draw_idle();
        if ($urandom_range(0, 39) == 0) idle_on = ~idle_on;
        return idle_on ? $urandom_range(0, 16) : 0;
    endfunction

    // driver: next word goes out once the current one is taken and the gap ran out
    always @(posedge i_clk) begin
        if (i_rst_n && (!i_in_valid || !o_in_stall)) begin
            if (i_in_valid) expected_words.push_back(histogram_result(i_in_word));
            if (send_gap != 0) begin
                i_in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_words.size() != 0) begin
                i_in_word <= pending_words.pop_front();
                i_in_valid <= 1'b1;
                send_gap <= draw_idle();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each taken result word, then stall for a drawn while
    always @(posedge i_clk) begin
        llhr_pkg::t_out_word exp_w;
        int        hold;
        if (o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $error("result word with no expectation waiting");
                mismatches++;
            end else begin
                exp_w = expected_words.pop_front();
                if (o_out_word.status !== exp_w.status) begin
                    $error("status exp %0d got %0d", exp_w.status, o_out_word.status);
                    mismatches++;
                end
                if (o_out_word.bucket_count_out !== exp_w.bucket_count_out) begin
                    $error("bucket_count_out exp %0d got %0d",
                           exp_w.bucket_count_out, o_out_word.bucket_count_out);
                    mismatches++;
                end
                if (o_out_word.percentile_value !== exp_w.percentile_value) begin
                    $error("percentile_value exp %0d got %0d",
                           exp_w.percentile_value, o_out_word.percentile_value);
                    mismatches++;
                end
                if (o_out_word.total_out !== exp_w.total_out) begin
                    $error("total_out exp %0d got %0d", exp_w.total_out, o_out_word.total_out);
                    mismatches++;
                end
                if (o_out_word.minimum_out !== exp_w.minimum_out) begin
                    $error("minimum_out exp %0d got %0d",
                           exp_w.minimum_out, o_out_word.minimum_out);
                    mismatches++;
                end
                if (o_out_word.maximum_out !== exp_w.maximum_out) begin
                    $error("maximum_out exp %0d got %0d",
                           exp_w.maximum_out, o_out_word.maximum_out);
                    mismatches++;
                end
            end
            hold = draw_idle();
            recv_wait <= hold;
            i_out_stall <= (hold != 0);
        end else if (recv_wait > 1) begin
            recv_wait <= recv_wait - 1;
            i_out_stall <= 1'b1;
        end else begin
            recv_wait <= 0;
            i_out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function llhr_pkg::t_in_word make_word(llhr_pkg::t_op op, logic [62:0] value,
                                           logic [31:0] inc, logic [15:0] pct);
        llhr_pkg::t_in_word w;
        w.op = op;
        w.sample_value = value;
        w.increment = inc;
        w.percentile = pct;
        return w;
    endfunction

    function logic [62:0] rand_value();
        logic [62:0] v;
        v = 63'({$urandom, $urandom});
        return v >> $urandom_range(0, 62);
    endfunction

    // mostly records, with lookups of recorded or random values and occasional percentiles
    task automatic queue_random(int count);
        logic [62:0] seen [$];
        logic [62:0] v;
        logic [31:0] inc;
        logic [15:0] pct;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            v = (seen.size() != 0 && $urandom_range(0, 2) == 0)
                ? seen[$urandom_range(0, seen.size() - 1)] : rand_value();
            case ($urandom_range(0, 3))
                0: inc = $urandom;
                1: inc = 32'd0;
                default: inc = $urandom_range(1, 20);
            endcase
            pct = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10000));
            if (pick < 60) begin
                seen.push_back(v);
                pending_words.push_back(make_word(llhr_pkg::OP_RECORD, v, inc, pct));
            end else if (pick < 84) begin
                pending_words.push_back(make_word(llhr_pkg::OP_COUNT, v, inc, pct));
            end else if (pick < 96) begin
                pending_words.push_back(make_word(llhr_pkg::OP_PCTL, v, inc, pct));
            end else begin
                pending_words.push_back(make_word(llhr_pkg::OP_NOP, v, inc, pct));
            end
        end
    endtask

    // block drained: nothing queued, nothing in flight, then a settle pause
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_words.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(llhr_pkg::t_cfg_idx idx, logic [62:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == llhr_pkg::CFG_HIGHEST) cfg_highest = data;
        else cfg_digits = data[2:0];
        relayout();
    endtask

    task automatic run_phase(logic [62:0] high, logic [2:0] digits, int count);
        wait_drained();
        write_reg(llhr_pkg::CFG_HIGHEST, high);
        write_reg(llhr_pkg::CFG_DIGITS, {60'd0, digits});
        queue_random(count);
    endtask

    initial begin
        cfg_highest = llhr_pkg::HIGH_RESET;
        cfg_digits = llhr_pkg::DIGITS_RESET;
        relayout();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, field extremes, every op, clamping
        pending_words.push_back(make_word(llhr_pkg::OP_PCTL, '0, '0, 16'd5000));
        pending_words.push_back(make_word(llhr_pkg::OP_COUNT, '0, '0, '0));
        pending_words.push_back(make_word(llhr_pkg::OP_RECORD, '0, 32'd1, '0));
        pending_words.push_back(make_word(llhr_pkg::OP_RECORD, MAX63, '1, '1));
        pending_words.push_back(make_word(llhr_pkg::OP_RECORD, 63'd5, 32'd0, '0));
        pending_words.push_back(make_word(llhr_pkg::OP_RECORD, 63'd4294967296, 32'd7, '0));
        pending_words.push_back(make_word(llhr_pkg::OP_COUNT, MAX63, '0, '0));
        pending_words.push_back(make_word(llhr_pkg::OP_COUNT, 63'd4294967295, '0, '0));
        pending_words.push_back(make_word(llhr_pkg::OP_COUNT, 63'd5, '0, '0));
        pending_words.push_back(make_word(llhr_pkg::OP_PCTL, '0, '0, 16'd0));
        pending_words.push_back(make_word(llhr_pkg::OP_PCTL, '0, '0, 16'd1));
        pending_words.push_back(make_word(llhr_pkg::OP_PCTL, '0, '0, 16'd10000));
        pending_words.push_back(make_word(llhr_pkg::OP_PCTL, MAX63, '1, 16'hffff));
        pending_words.push_back(make_word(llhr_pkg::OP_NOP, MAX63, '1, 16'hffff));
        pending_words.push_back(make_word(llhr_pkg::OP_RECORD, 63'd300, 32'd3, '0));
        pending_words.push_back(make_word(llhr_pkg::OP_PCTL, '0, '0, 16'd9999));
        queue_random(150);

        // tiny layout at the lowest tracked value, digits below range
        run_phase(63'd2, 3'd1, 80);
        run_phase(63'd0, 3'd0, 60);
        // store needs more entries than it has
        run_phase(63'd1048576, 3'd3, 20);
        // exactly fills the store
        run_phase(63'd5000, 3'd3, 100);
        // widest value range, entry floors reach the top of 63 bits
        run_phase(MAX63, 3'd1, 150);
        run_phase(MAX63, 3'd7, 20);
        run_phase(63'd1, 3'd6, 20);
        run_phase(63'd1099511627776, 3'd2, 150);
        run_phase(63'd40000, 3'd4, 60);
        wait_drained();

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### log_linear_histogram_recorder.f
hw/rtl/llhr_pkg.sv
hw/rtl/llhr_ram.sv
hw/rtl/llhr_dp.sv
hw/rtl/llhr_ctrl.sv
hw/rtl/log_linear_histogram_recorder.sv
bench/tb.sv
